// ----- design/cnlp_pkg.sv -----
`timescale 1ns / 1ps

package cnlp_pkg;

  // Parser phases of the reply text.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEN,
    PH_LENLF,
    PH_NODESTART,
    PH_FIELD,
    PH_SLOTBEGIN,
    PH_SLOTEND,
    PH_SLOTMOVE,
    PH_FINISHED,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    ST_CONTINUE = 3'd0,
    ST_FIELD    = 3'd1,
    ST_NODE     = 3'd2,
    ST_FINISHED = 3'd3,
    ST_ERROR    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ROLE_UNKNOWN = 2'd0,
    ROLE_MASTER  = 2'd1,
    ROLE_SLAVE   = 2'd2
  } role_t;

  // Widths fixed by the field definitions.
  localparam int FILL_W  = 7;
  localparam int FNUM_W  = 4;
  localparam int SLOT_W  = 17;

  // One result word.
  typedef struct packed {
    status_t     status;
    logic [1:0]  field_index;
    logic [7:0]  field_char;
    role_t       node_role;
    logic        address_cleared;
    logic [15:0] slot_first;
    logic [15:0] slot_after;
  } res_t;

  // Contents of the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

endpackage

// ----- design/cnlp_in_if.sv -----
`timescale 1ns / 1ps

interface cnlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ----- design/cnlp_out_if.sv -----
`timescale 1ns / 1ps

interface cnlp_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [1:0]        field_index;
  logic [7:0]        field_char;
  logic [1:0]        node_role;
  logic              address_cleared;
  logic signed [15:0] slot_first;
  logic signed [15:0] slot_after;

  modport source (output valid, output status, output field_index, output field_char,
                  output node_role, output address_cleared, output slot_first,
                  output slot_after, input ready);
  modport sink (input valid, input status, input field_index, input field_char,
                input node_role, input address_cleared, input slot_first,
                input slot_after, output ready);
endinterface

// ----- design/cnlp_in_reg.sv -----
`timescale 1ns / 1ps

module cnlp_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  cnlp_in_if.sink          in_chan,
  input  logic             take,
  output cnlp_pkg::stage_t stage
);
  import cnlp_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;
  logic       load;

  // The register can refill in the same cycle its word moves on.
  assign in_chan.ready = !valid_r || take;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_chan.data_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

// ----- design/cnlp_out_reg.sv -----
`timescale 1ns / 1ps

module cnlp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  cnlp_pkg::res_t res,
  output logic           free,
  cnlp_out_if.source     out_chan
);
  import cnlp_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid           = valid_r;
  assign out_chan.status          = res_r.status;
  assign out_chan.field_index     = res_r.field_index;
  assign out_chan.field_char      = res_r.field_char;
  assign out_chan.node_role       = res_r.node_role;
  assign out_chan.address_cleared = res_r.address_cleared;
  assign out_chan.slot_first      = $signed(res_r.slot_first);
  assign out_chan.slot_after      = $signed(res_r.slot_after);

endmodule

// ----- design/cnlp_parser.sv -----
`timescale 1ns / 1ps

module cnlp_parser #(
  parameter int FIELD_CAPACITY      = 64,
  parameter int SLOT_FIELD_POSITION = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     c,
  output cnlp_pkg::res_t res
);
  import cnlp_pkg::*;

  localparam logic [FILL_W-1:0] CAP      = FIELD_CAPACITY[FILL_W-1:0];
  localparam logic [FNUM_W-1:0] SLOT_POS = SLOT_FIELD_POSITION[FNUM_W-1:0];
  localparam logic [SLOT_W-1:0] SLOT_MAX = 17'd16384;
  localparam logic [SLOT_W-1:0] SLOT_NONE = '1;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BRACK  = 8'h5B;
  localparam logic [47:0] PAT_MASTER = 48'h6D6173746572;
  localparam logic [39:0] PAT_SLAVE  = 40'h736C617665;
  localparam logic [47:0] PAT_NOADDR = 48'h6E6F61646472;

  // Decimal accumulate of a nonnegative slot value, saturating.
  function automatic logic [SLOT_W-1:0] sat_mac(logic [SLOT_W-1:0] v, logic [3:0] d);
    logic [SLOT_W+1:0] w;
    w = ({2'b00, v} << 3) + ({2'b00, v} << 1) + {{(SLOT_W-2){1'b0}}, d};
    return (w > {2'b00, SLOT_MAX}) ? SLOT_MAX : w[SLOT_W-1:0];
  endfunction

  // Exclusive end from an inclusive one; minus one turns into zero.
  function automatic logic [SLOT_W-1:0] sat_inc(logic [SLOT_W-1:0] v);
    logic [SLOT_W-1:0] s;
    s = v + 17'd1;
    return (!s[SLOT_W-1] && (s > SLOT_MAX)) ? SLOT_MAX : s;
  endfunction

  phase_t              phase_r, phase_nxt;
  logic [FNUM_W-1:0]   fnum_r, fnum_nxt;
  logic [FILL_W-1:0]   fill_r [4];
  logic [FILL_W-1:0]   fill_nxt [4];
  logic [39:0]         recent_r, recent_nxt;
  logic [2:0]          hits_r, hits_nxt;
  role_t               role_r, role_nxt;
  logic                noaddr_r, noaddr_nxt;
  logic [SLOT_W-1:0]   rf_r, rf_nxt;
  logic [SLOT_W-1:0]   ra_r, ra_nxt;

  // Line state as seen by this byte: the first byte of a line starts fresh.
  logic                nl;
  logic [FNUM_W-1:0]   fn_e;
  logic [FILL_W-1:0]   fill_e [4];
  logic [39:0]         recent_e;
  logic [2:0]          hits_e;
  role_t               role_e;
  logic                noaddr_e;
  logic [SLOT_W-1:0]   rf_e, ra_e;

  logic                digit;
  logic [3:0]          dval;
  logic                fn_low;
  logic                full;
  logic [47:0]         seq;
  logic [SLOT_W-1:0]   end_first, end_after;

  assign digit = (c >= 8'h30) && (c <= 8'h39);
  assign dval  = c[3:0];
  assign nl    = (phase_r == PH_NODESTART) && (c != CH_CR);

  always_comb begin
    fn_e     = nl ? '0 : fnum_r;
    recent_e = nl ? '0 : recent_r;
    hits_e   = nl ? '0 : hits_r;
    role_e   = nl ? ROLE_UNKNOWN : role_r;
    noaddr_e = nl ? 1'b0 : noaddr_r;
    rf_e     = nl ? SLOT_NONE : rf_r;
    ra_e     = nl ? SLOT_NONE : ra_r;
    for (int i = 0; i < 4; i++) begin
      fill_e[i] = nl ? '0 : fill_r[i];
    end
  end

  assign fn_low    = (fn_e < 4'd4);
  assign full      = fill_e[fn_e[1:0]] >= CAP;
  assign seq       = {recent_e, c};
  assign end_first = sat_inc(rf_e);
  assign end_after = sat_inc(ra_e);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE:   phase_nxt = (c == CH_DOLLAR) ? PH_LEN : PH_ERROR;
      PH_LEN: begin
        if (digit) begin
          phase_nxt = PH_LEN;
        end else if (c == CH_CR) begin
          phase_nxt = PH_LENLF;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_LENLF:  phase_nxt = (c == CH_LF) ? PH_NODESTART : PH_ERROR;
      PH_NODESTART, PH_FIELD: begin
        priority if (phase_r == PH_NODESTART && c == CH_CR) begin
          phase_nxt = PH_FINISHED;
        end else if (c == CH_SPACE) begin
          phase_nxt = ((fn_e + 4'd1) == SLOT_POS) ? PH_SLOTBEGIN : PH_FIELD;
        end else if (c == CH_LF) begin
          phase_nxt = PH_NODESTART;
        end else if (fn_low && full) begin
          phase_nxt = PH_ERROR;
        end else begin
          phase_nxt = PH_FIELD;
        end
      end
      PH_SLOTBEGIN: begin
        priority if (digit || c == CH_SPACE) begin
          phase_nxt = PH_SLOTBEGIN;
        end else if (c == CH_DASH) begin
          phase_nxt = PH_SLOTEND;
        end else if (c == CH_BRACK) begin
          phase_nxt = PH_SLOTMOVE;
        end else if (c == CH_LF) begin
          phase_nxt = PH_NODESTART;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_SLOTEND: begin
        priority if (digit) begin
          phase_nxt = PH_SLOTEND;
        end else if (c == CH_SPACE) begin
          phase_nxt = PH_SLOTBEGIN;
        end else if (c == CH_LF) begin
          phase_nxt = PH_NODESTART;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_SLOTMOVE: begin
        priority if (c == CH_SPACE) begin
          phase_nxt = PH_SLOTBEGIN;
        end else if (c == CH_LF) begin
          phase_nxt = PH_NODESTART;
        end else begin
          phase_nxt = PH_SLOTMOVE;
        end
      end
      PH_FINISHED: phase_nxt = PH_FINISHED;
      default:     phase_nxt = PH_ERROR;
    endcase
  end

  // Result word and line state.
  always_comb begin
    res        = '0;
    fnum_nxt   = fn_e;
    recent_nxt = recent_e;
    hits_nxt   = hits_e;
    role_nxt   = role_e;
    noaddr_nxt = noaddr_e;
    rf_nxt     = rf_e;
    ra_nxt     = ra_e;
    fill_nxt   = fill_e;
    unique case (phase_r)
      PH_IDLE: begin
        if (c != CH_DOLLAR) begin
          res.status = ST_ERROR;
        end
      end
      PH_LEN: begin
        if (!digit && c != CH_CR) begin
          res.status = ST_ERROR;
        end
      end
      PH_LENLF: begin
        if (c != CH_LF) begin
          res.status = ST_ERROR;
        end
      end
      PH_NODESTART, PH_FIELD: begin
        priority if (phase_r == PH_NODESTART && c == CH_CR) begin
          res.status = ST_FINISHED;
        end else if (c == CH_SPACE) begin
          if (fn_e == 4'd2) begin
            // Master wins over slave when both were seen.
            if (hits_e[0]) begin
              role_nxt = ROLE_MASTER;
            end else if (hits_e[1]) begin
              role_nxt = ROLE_SLAVE;
            end
            if (hits_e[2]) begin
              noaddr_nxt = 1'b1;
            end
          end
          fnum_nxt = fn_e + 4'd1;
        end else if (c == CH_LF) begin
          res.status          = ST_NODE;
          res.node_role       = role_e;
          res.address_cleared = noaddr_e;
          res.slot_first      = rf_e[15:0];
          res.slot_after      = ra_e[15:0];
        end else if (fn_low) begin
          if (full) begin
            res.status = ST_ERROR;
          end else begin
            fill_nxt[fn_e[1:0]] = fill_e[fn_e[1:0]] + 7'd1;
            if (fn_e == 4'd2) begin
              hits_nxt[0] = hits_e[0] | (seq == PAT_MASTER);
              hits_nxt[1] = hits_e[1] | (seq[39:0] == PAT_SLAVE);
              hits_nxt[2] = hits_e[2] | (seq == PAT_NOADDR);
              recent_nxt  = seq[39:0];
            end
            res.status      = ST_FIELD;
            res.field_index = fn_e[1:0];
            res.field_char  = c;
          end
        end
      end
      PH_SLOTBEGIN: begin
        priority if (digit) begin
          rf_nxt = rf_e[SLOT_W-1] ? {13'd0, dval} : sat_mac(rf_e, dval);
        end else if (c == CH_DASH) begin
          ra_nxt = '0;
        end else if (c == CH_BRACK) begin
          rf_nxt = rf_e;
        end else if (c == CH_SPACE || c == CH_LF) begin
          res.status          = ST_NODE;
          res.node_role       = role_e;
          res.address_cleared = noaddr_e;
          res.slot_first      = rf_e[15:0];
          res.slot_after      = end_first[15:0];
          if (c == CH_LF) begin
            ra_nxt = end_first;
          end else begin
            rf_nxt = SLOT_NONE;
            ra_nxt = SLOT_NONE;
          end
        end else begin
          res.status = ST_ERROR;
        end
      end
      PH_SLOTEND: begin
        priority if (digit) begin
          ra_nxt = sat_mac(ra_e, dval);
        end else if (c == CH_SPACE || c == CH_LF) begin
          res.status          = ST_NODE;
          res.node_role       = role_e;
          res.address_cleared = noaddr_e;
          res.slot_first      = rf_e[15:0];
          res.slot_after      = end_after[15:0];
          if (c == CH_LF) begin
            ra_nxt = end_after;
          end else begin
            rf_nxt = SLOT_NONE;
            ra_nxt = SLOT_NONE;
          end
        end else begin
          res.status = ST_ERROR;
        end
      end
      PH_SLOTMOVE: begin
        // Migration entries are skipped up to the next space.
        if (c == CH_SPACE) begin
          rf_nxt = SLOT_NONE;
          ra_nxt = SLOT_NONE;
        end else if (c == CH_LF) begin
          res.status          = ST_NODE;
          res.node_role       = role_e;
          res.address_cleared = noaddr_e;
          res.slot_first      = rf_e[15:0];
          res.slot_after      = ra_e[15:0];
        end
      end
      PH_FINISHED: res.status = ST_FINISHED;
      default:     res.status = ST_ERROR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      fnum_r   <= '0;
      recent_r <= '0;
      hits_r   <= '0;
      role_r   <= ROLE_UNKNOWN;
      noaddr_r <= 1'b0;
      rf_r     <= SLOT_NONE;
      ra_r     <= SLOT_NONE;
      for (int i = 0; i < 4; i++) begin
        fill_r[i] <= '0;
      end
    end else if (step) begin
      phase_r  <= phase_nxt;
      fnum_r   <= fnum_nxt;
      recent_r <= recent_nxt;
      hits_r   <= hits_nxt;
      role_r   <= role_nxt;
      noaddr_r <= noaddr_nxt;
      rf_r     <= rf_nxt;
      ra_r     <= ra_nxt;
      for (int i = 0; i < 4; i++) begin
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("error phase was left");

  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FINISHED |=> phase_r == PH_FINISHED)
    else $error("finished phase was left");

  a_first_range: assert property (@(posedge clk) disable iff (!rst_n)
    rf_r[SLOT_W-1] ? (rf_r == SLOT_NONE) : (rf_r <= SLOT_MAX))
    else $error("first slot out of range");

  a_dollar_start: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_IDLE && res.status != ST_ERROR |=> phase_r == PH_LEN)
    else $error("accepted dollar sign did not start the length");
`endif

endmodule

// ----- design/cluster_node_list_parser_core.sv -----
`timescale 1ns / 1ps
// A byte accepted into the input register is parsed and its word loaded into the result
// register, from which the receiver takes it; a stalled result holds it longer.
// Throughput: one byte per cycle while the receiver keeps taking results, one result word
// per byte, set by the combinational update of the parse state between the two registers.
// Reset: synchronous, active low; the parser returns to waiting for a dollar sign.

module cluster_node_list_parser_core #(
  parameter int FIELD_CAPACITY      = 64,
  parameter int SLOT_FIELD_POSITION = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  cnlp_in_if.sink     in_chan,
  cnlp_out_if.source  out_chan
);
  import cnlp_pkg::*;

  stage_t stage;
  res_t   res;
  logic   out_free;
  logic   step;

  // A byte in the input register is parsed when the result register can take
  // its word: either it is empty or its word leaves in this same cycle.
  assign step = stage.valid && out_free;

  // Input register; it refills in the cycle its byte is parsed, so a new word
  // is taken every cycle while results flow.
  cnlp_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .take    (step),
    .stage   (stage)
  );

  // Parse state and the combinational update for one byte. All state
  // advances only when a byte is parsed, so stalls on either side hold it.
  cnlp_parser #(
    .FIELD_CAPACITY      (FIELD_CAPACITY),
    .SLOT_FIELD_POSITION (SLOT_FIELD_POSITION)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .c     (stage.data),
    .res   (res)
  );

  // Result register that drives the output channel.
  cnlp_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .res      (res),
    .free     (out_free),
    .out_chan (out_chan)
  );

endmodule

// ----- tb/cluster_node_list_parser_core_tb.sv -----
`timescale 1ns / 1ps

module cluster_node_list_parser_core_tb;
  import cnlp_pkg::*;

  // The block under test runs with its default sizes; the parse model below uses the same.
  localparam int FIELD_CAP   = 64;
  localparam int SLOT_POS    = 8;
  localparam int SLOT_MAX    = 16384;
  // Two register stages sit between an accepted byte and its result word.
  localparam int LATENCY_TAIL = 8;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 600000;

  localparam logic [7:0] CH_DOLLAR = "$";
  localparam logic [7:0] CH_LBRACK = "[";
  localparam logic [7:0] CH_DASH   = "-";
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_ZERO   = "0";
  localparam logic [7:0] CH_NINE   = "9";
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [47:0] PAT_MASTER = "master";
  localparam logic [39:0] PAT_SLAVE  = "slave";
  localparam logic [47:0] PAT_NOADDR = "noaddr";

  // The ways the reply can be brought to its sticky end.
  typedef enum int {
    END_FINISH,
    END_OVERFLOW,
    END_BAD_SLOT,
    END_BAD_RANGE
  } reply_end_t;

  logic clk;
  logic rst_n;

  cnlp_in_if  in_bus ();
  cnlp_out_if out_bus ();

  cluster_node_list_parser_core #(
    .FIELD_CAPACITY      (FIELD_CAP),
    .SLOT_FIELD_POSITION (SLOT_POS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Run bookkeeping.
  int cycle_count;
  int mismatches;
  int bytes_sent;
  int words_seen;

  // Idling controls. The sender and the receiver each either run flat out or insert gaps.
  bit src_idle;
  bit sink_idle;
  bit long_hold_req;
  int hold_left;
  int stall_left;

  // Result words the parser is expected to deliver, oldest first.
  res_t expected_words[$];
  // Bytes of the node line that is being assembled for sending.
  logic [7:0] line_bytes[$];

  // Parse state of the model, one copy of every register the block keeps.
  phase_t      ps_phase;
  logic [31:0] ps_len;
  logic [3:0]  ps_field;
  int          ps_fill[4];
  logic [39:0] ps_window;
  logic [2:0]  ps_hits;
  role_t       ps_role;
  logic        ps_noaddr;
  int          ps_first;
  int          ps_after;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Everything a node line starts from: no role, no fields, no slot range.
  function automatic void start_line();
    ps_role   = ROLE_UNKNOWN;
    ps_noaddr = 1'b0;
    ps_field  = '0;
    for (int i = 0; i < 4; i++) ps_fill[i] = 0;
    ps_window = '0;
    ps_hits   = '0;
    ps_first  = -1;
    ps_after  = -1;
  endfunction

  function automatic void reset_parse_model();
    ps_phase = PH_IDLE;
    ps_len   = '0;
    start_line();
  endfunction

  function automatic int sat_slot(input int v);
    return (v > SLOT_MAX) ? SLOT_MAX : v;
  endfunction

  function automatic res_t node_word();
    res_t r;
    r = '0;
    r.status          = ST_NODE;
    r.node_role       = ps_role;
    r.address_cleared = ps_noaddr;
    r.slot_first      = ps_first[15:0];
    r.slot_after      = ps_after[15:0];
    return r;
  endfunction

  // Advances the parse model by one byte and returns the word the block should answer with.
  function automatic res_t predict_byte(input logic [7:0] c);
    res_t        r;
    logic        digit;
    logic        bad;
    int          d;
    logic [47:0] seq;
    r     = '0;
    bad   = 1'b0;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d     = int'(c) - int'(CH_ZERO);

    // A CR where a line would begin ends the reply; anything else opens a new line.
    if (ps_phase == PH_NODESTART) begin
      if (c == CH_CR) begin
        ps_phase = PH_FINISHED;
        r.status = ST_FINISHED;
        return r;
      end
      start_line();
      ps_phase = PH_FIELD;
    end

    case (ps_phase)
      PH_IDLE: begin
        if (c != CH_DOLLAR) bad = 1'b1;
        else ps_phase = PH_LEN;
      end
      PH_LEN: begin
        if (digit) ps_len = ps_len * 10 + d;
        else if (c == CH_CR) ps_phase = PH_LENLF;
        else bad = 1'b1;
      end
      PH_LENLF: begin
        if (c != CH_LF) bad = 1'b1;
        else ps_phase = PH_NODESTART;
      end
      PH_FIELD: begin
        if (c == CH_SPACE) begin
          // The role is settled once the flags field closes.
          if (ps_field == 2) begin
            if (ps_hits[0]) ps_role = ROLE_MASTER;
            else if (ps_hits[1]) ps_role = ROLE_SLAVE;
            if (ps_hits[2]) ps_noaddr = 1'b1;
          end
          ps_field = ps_field + 1'b1;
          if (ps_field == SLOT_POS) ps_phase = PH_SLOTBEGIN;
        end else if (c == CH_LF) begin
          ps_phase = PH_NODESTART;
          r = node_word();
        end else if (ps_field < 4) begin
          if (ps_fill[ps_field[1:0]] >= FIELD_CAP) begin
            bad = 1'b1;
          end else begin
            ps_fill[ps_field[1:0]]++;
            if (ps_field == 2) begin
              seq = {ps_window, c};
              if (seq == PAT_MASTER) ps_hits[0] = 1'b1;
              if (seq[39:0] == PAT_SLAVE) ps_hits[1] = 1'b1;
              if (seq == PAT_NOADDR) ps_hits[2] = 1'b1;
              ps_window = seq[39:0];
            end
            r.status      = ST_FIELD;
            r.field_index = ps_field[1:0];
            r.field_char  = c;
          end
        end
      end
      PH_SLOTBEGIN: begin
        if (digit) begin
          ps_first = (ps_first < 0) ? d : sat_slot(ps_first * 10 + d);
        end else if (c == CH_DASH) begin
          ps_phase = PH_SLOTEND;
          ps_after = 0;
        end else if (c == CH_LBRACK) begin
          ps_phase = PH_SLOTMOVE;
        end else if (c == CH_SPACE || c == CH_LF) begin
          ps_after = sat_slot(ps_first + 1);
          r = node_word();
          if (c == CH_LF) begin
            ps_phase = PH_NODESTART;
          end else begin
            ps_first = -1;
            ps_after = -1;
          end
        end else begin
          bad = 1'b1;
        end
      end
      PH_SLOTEND: begin
        if (digit) begin
          ps_after = sat_slot(ps_after * 10 + d);
        end else if (c == CH_SPACE || c == CH_LF) begin
          ps_after = sat_slot(ps_after + 1);
          r = node_word();
          if (c == CH_LF) begin
            ps_phase = PH_NODESTART;
          end else begin
            ps_phase = PH_SLOTBEGIN;
            ps_first = -1;
            ps_after = -1;
          end
        end else begin
          bad = 1'b1;
        end
      end
      PH_SLOTMOVE: begin
        // A migration entry is skipped up to the next space.
        if (c == CH_SPACE) begin
          ps_phase = PH_SLOTBEGIN;
          ps_first = -1;
          ps_after = -1;
        end else if (c == CH_LF) begin
          ps_phase = PH_NODESTART;
          r = node_word();
        end
      end
      PH_FINISHED: r.status = ST_FINISHED;
      default: bad = 1'b1;
    endcase

    if (bad) begin
      ps_phase = PH_ERROR;
      r        = '0;
      r.status = ST_ERROR;
    end
    return r;
  endfunction

  // Most gaps are short; now and then one is long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Line assembly helpers.
  function automatic void add_byte(input logic [7:0] b);
    line_bytes.push_back(b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  // Any byte that does not split a field or a line.
  function automatic logic [7:0] rand_field_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_SPACE || b == CH_LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic void add_rand_bytes(input int n);
    for (int i = 0; i < n; i++) line_bytes.push_back(rand_field_byte());
  endfunction

  function automatic void add_hex(input int n);
    string digits;
    digits = "0123456789abcdef";
    for (int i = 0; i < n; i++) line_bytes.push_back(digits[$urandom_range(0, 15)]);
  endfunction

  function automatic string flag_word(input int k);
    case (k)
      0: return "master";
      1: return "slave";
      2: return "noaddr";
      3: return "myself";
      4: return "fail?";
      5: return "handshake";
      6: return "mastr";
      7: return "noaddress";
      default: return "slav";
    endcase
  endfunction

  function automatic string slot_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $sformatf("%0d", $urandom_range(0, 16383));
    if (r < 90) return $sformatf("0%0d", $urandom_range(0, 999));
    return $sformatf("%0d", $urandom_range(16383, 2000000));
  endfunction

  // A byte that is illegal inside a slot number.
  function automatic logic [7:0] bad_slot_byte();
    logic [7:0] b;
    b = rand_field_byte();
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DASH || b == CH_LBRACK) begin
      b = rand_field_byte();
    end
    return b;
  endfunction

  // Builds one random node line into line_bytes. Most lines are complete and well formed
  // with random content; some end early and a few are noise that stays short of the slots.
  function automatic void build_random_line();
    int r;
    int stop_at;
    int spaces;
    int n;
    int k;
    line_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      spaces = 0;
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 20 && spaces < SLOT_POS - 1) begin
          add_byte(CH_SPACE);
          spaces++;
        end else begin
          add_byte(rand_field_byte());
        end
      end
      add_byte(CH_LF);
    end else begin
      stop_at = (r < 85) ? 99 : $urandom_range(0, SLOT_POS - 1);
      for (int f = 0; f < SLOT_POS; f++) begin
        r = $urandom_range(0, 99);
        case (f)
          0: begin
            if (r < 50) add_hex($urandom_range(1, 12));
            else if (r < 80) add_rand_bytes($urandom_range(1, 10));
            else if (r < 95) add_hex(40);
            else add_rand_bytes(FIELD_CAP);
          end
          1: begin
            if (r < 60) add_text($sformatf("%0d.%0d.%0d.%0d:%0d@%0d", $urandom_range(0, 255),
                                           $urandom_range(0, 255), $urandom_range(0, 255),
                                           $urandom_range(0, 255), $urandom_range(0, 65535),
                                           $urandom_range(0, 65535)));
            else if (r < 95) add_rand_bytes($urandom_range(0, 8));
            else add_rand_bytes(FIELD_CAP);
          end
          2: begin
            if (r < 85) begin
              k = $urandom_range(1, 3);
              for (int i = 0; i < k; i++) begin
                if (i > 0) add_text(",");
                add_text(flag_word($urandom_range(0, 8)));
              end
            end else if (r < 95) begin
              add_rand_bytes($urandom_range(1, 12));
            end else begin
              add_rand_bytes(FIELD_CAP);
            end
          end
          3: begin
            if (r < 50) add_text("-");
            else if (r < 80) add_hex($urandom_range(1, 8));
            else add_rand_bytes($urandom_range(0, FIELD_CAP));
          end
          default: begin
            if (r < 50) add_text($sformatf("%0d", $urandom_range(0, 99999)));
            else if (r < 75) add_text("connected");
            else add_rand_bytes($urandom_range(0, 5));
          end
        endcase
        if (f == stop_at) begin
          add_byte(CH_LF);
          break;
        end
        add_byte(CH_SPACE);
      end
      if (stop_at == 99) begin
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            add_text(slot_number());
          end else if (r < 75) begin
            if ($urandom_range(0, 19) != 0) add_text(slot_number());
            add_byte(CH_DASH);
            if ($urandom_range(0, 19) != 0) add_text(slot_number());
          end else if (r < 85) begin
            add_text({"[", slot_number(), ($urandom_range(0, 1) != 0) ? "->-" : "-<-"});
            add_hex(6);
            if (i < n - 1 || $urandom_range(0, 1) != 0) add_text("]");
          end else if (r >= 92) begin
            add_text("99999");
          end
          if (i < n - 1) add_byte(CH_SPACE);
        end
        if ($urandom_range(0, 3) == 0) add_byte(CH_SPACE);
        add_byte(CH_LF);
      end
    end
    // A CR in the first position would end the whole reply.
    if (line_bytes[0] == CH_CR) line_bytes[0] = "x";
  endfunction

  // Offers one byte and waits for it to be taken. Valid is left high on return so that a
  // following byte can go out back to back.
  task automatic send_byte(input logic [7:0] b);
    int   gap;
    logic taken;
    gap = (src_idle && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    taken = 1'b0;
    // Ready is looked at mid cycle, where it is settled for the coming edge.
    while (!taken) begin
      @(negedge clk);
      taken = in_bus.ready;
      @(posedge clk);
    end
    bytes_sent++;
    expected_words.push_back(predict_byte(b));
  endtask

  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  // Stops offering and waits for every outstanding word to come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH word %0d %s: got %0d, expected %0d", words_seen, what, got, want);
    mismatches++;
  endtask

  // Compares one delivered word with the oldest expectation.
  task automatic check_word();
    res_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("without expectation, status", int'(out_bus.status), -1);
    end else begin
      want = expected_words.pop_front();
      if (out_bus.status !== want.status)
        report_mismatch("status", int'(out_bus.status), int'(want.status));
      if (out_bus.field_index !== want.field_index)
        report_mismatch("field_index", int'(out_bus.field_index), int'(want.field_index));
      if (out_bus.field_char !== want.field_char)
        report_mismatch("field_char", int'(out_bus.field_char), int'(want.field_char));
      if (out_bus.node_role !== want.node_role)
        report_mismatch("node_role", int'(out_bus.node_role), int'(want.node_role));
      if (out_bus.address_cleared !== want.address_cleared)
        report_mismatch("address_cleared", int'(out_bus.address_cleared),
                        int'(want.address_cleared));
      if (out_bus.slot_first !== want.slot_first)
        report_mismatch("slot_first", int'(out_bus.slot_first),
                        int'($signed(want.slot_first)));
      if (out_bus.slot_after !== want.slot_after)
        report_mismatch("slot_after", int'(out_bus.slot_after),
                        int'($signed(want.slot_after)));
    end
    words_seen++;
  endtask

  // Result words are taken mid cycle: valid and ready seen high here hold up to the next edge,
  // where the word is accepted.
  always @(negedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) check_word();
  end

  // Receiver. A long hold requested by a test is counted down here; otherwise, when idling
  // is on, random stalls are inserted.
  initial begin
    out_bus.ready = 1'b0;
    hold_left     = 0;
    stall_left    = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (sink_idle && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The bulk-string header. The length has every digit and overflows 32 bits.
  task automatic test_header();
    line_bytes.delete();
    add_text("$9876543210");
    add_byte(CH_CR);
    add_byte(CH_LF);
    send_line();
  endtask

  // Short hand-written lines: an empty line, a line that ends inside the flags field, a line
  // with extreme bytes, a range up to the top slot, a migration entry, an empty slot item and
  // a saturating slot, and a line that ends inside a migration entry.
  task automatic test_directed_lines();
    line_bytes.delete();
    add_byte(CH_LF);
    add_text("i a master");
    add_byte(CH_LF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text(" 10.0.0.1:6379 master,noaddr - ");
    add_byte(8'hFF);
    add_text(" 0 0 c 0-16383 [1-<-x]  99999");
    add_byte(CH_LF);
    add_text("i a slave,myself - 0 0 1 c 5[z");
    add_byte(CH_LF);
    send_line();
  endtask

  // Random node lines until the byte count reaches the given mark. The idling mix changes
  // from line to line, with some lines sent with no idling at all.
  task automatic test_random_lines(input int upto);
    int r;
    while (bytes_sent < upto) begin
      r = $urandom_range(0, 3);
      src_idle  = (r != 0) && ($urandom_range(0, 3) != 0);
      sink_idle = (r != 0) && ($urandom_range(0, 3) != 0);
      build_random_line();
      send_line();
    end
  endtask

  // The receiver stops for a long stretch while the sender keeps offering, so the block
  // fills up and holds off its input.
  task automatic test_backpressure();
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 2; i++) begin
      build_random_line();
      send_line();
    end
  endtask

  // The sender pauses until every word is back, then picks up again.
  task automatic test_drain_pause();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    build_random_line();
    send_line();
    wait_drained();
  endtask

  // Reset is applied only once, so the reply can end only once per run: either a CR at the
  // start of a line or one of the framing errors reachable after the header, chosen at
  // random. Random bytes follow to show that the end state sticks.
  task automatic test_reply_end();
    reply_end_t kind;
    kind = reply_end_t'($urandom_range(0, 3));
    line_bytes.delete();
    case (kind)
      END_FINISH: add_byte(CH_CR);
      END_OVERFLOW: add_rand_bytes(FIELD_CAP + 1);
      END_BAD_SLOT: begin
        add_text("t a master - 0 0 1 c 12");
        add_byte(bad_slot_byte());
      end
      default: begin
        add_text("t a slave - 0 0 1 c 3-4");
        add_byte(bad_slot_byte());
      end
    endcase
    for (int i = 0; i < 16; i++) add_byte(8'($urandom_range(0, 255)));
    send_line();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    bytes_sent       = 0;
    src_idle         = 1'b1;
    sink_idle        = 1'b1;
    long_hold_req    = 1'b0;
    reset_parse_model();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header();
    test_directed_lines();
    test_random_lines(350);
    test_backpressure();
    test_random_lines(650);
    test_drain_pause();
    test_random_lines(850);
    test_reply_end();

    wait_drained();
    repeat (LATENCY_TAIL) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
